/* src/dda_line_point_generator_defines.svh */
// assertion helpers for the checker file
`ifndef DDA_LINE_POINT_GENERATOR_DEFINES_SVH
`define DDA_LINE_POINT_GENERATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define DDA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked from the cycle after the antecedent
`define DDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/dda_pkg.sv */
package dda_pkg;

   localparam int COORD_W   = 6;
   localparam int GRID_SIZE = 64;

   typedef enum logic [0:0] {
      CTRL_IDLE,
      CTRL_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } dda_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic step_last;
      logic out_free;
   } dda_status_type;

   // coordinates at or beyond the grid edge saturate to the last column or row
   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      r = v;
      if (int'(v) > GRID_SIZE - 1) begin
         r = COORD_W'(GRID_SIZE - 1);
      end
      return r;
   endfunction

endpackage

/* src/dda_line_point_generator.sv */
// DDA line point generator: takes one segment (start and end grid coordinates) per
// transaction and emits the points start + i*(end-start)/n for i = 1..n, with n the
// larger of the absolute x and y spans and the quotient truncated toward zero; the
// start point is not emitted, the final point has rsp_last set, and a segment with
// identical endpoints gives no points. Points come one per cycle from a running
// quotient/remainder update, as long as the result channel does not stall; a new
// segment is accepted only once the previous one has issued its last point, which
// may still be waiting in the output register.
module dda_line_point_generator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dda_pkg::COORD_W-1:0] req_x_start,
   input  logic [dda_pkg::COORD_W-1:0] req_y_start,
   input  logic [dda_pkg::COORD_W-1:0] req_x_end,
   input  logic [dda_pkg::COORD_W-1:0] req_y_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dda_pkg::COORD_W-1:0] rsp_point_x,
   output logic [dda_pkg::COORD_W-1:0] rsp_point_y,
   output logic                        rsp_last
);
   import dda_pkg::*;

   dda_cmd_type    cmd;
   dda_status_type status;

   dda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dda_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_last    (rsp_last)
   );

endmodule

/* src/dda_ctrl.sv */
module dda_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dda_pkg::dda_status_type status,
   output dda_pkg::dda_cmd_type    cmd
);
   import dda_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CTRL_RUN;
            end
         end
         CTRL_RUN: begin
            if (status.n_zero) begin
               // identical endpoints: nothing to emit
               state_in = CTRL_IDLE;
            end else if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.step_last) begin
                  state_in = CTRL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

endmodule

/* src/dda_datapath.sv */
module dda_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  dda_pkg::dda_cmd_type         cmd,
   output dda_pkg::dda_status_type      status,
   input  logic [dda_pkg::COORD_W-1:0]  req_x_start,
   input  logic [dda_pkg::COORD_W-1:0]  req_y_start,
   input  logic [dda_pkg::COORD_W-1:0]  req_x_end,
   input  logic [dda_pkg::COORD_W-1:0]  req_y_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dda_pkg::COORD_W-1:0]  rsp_point_x,
   output logic [dda_pkg::COORD_W-1:0]  rsp_point_y,
   output logic                         rsp_last
);
   import dda_pkg::*;

   localparam int ACC_W = COORD_W + 1;

   logic [COORD_W-1:0] xs, ys, xe, ye;
   logic               sx_load, sy_load;
   logic [COORD_W-1:0] adx_load, ady_load, n_load;

   logic [COORD_W-1:0] px_ff, py_ff;
   logic [COORD_W-1:0] pt_x_ff, pt_y_ff;
   logic [COORD_W-1:0] adx_ff, ady_ff, n_ff, i_ff;
   logic [COORD_W-1:0] rx_ff, ry_ff;
   logic               sx_ff, sy_ff;
   logic               last_ff;
   logic               valid_ff;

   logic [ACC_W-1:0]   rx_sum, ry_sum;
   logic               cx, cy;
   logic [COORD_W-1:0] rx_in, ry_in, px_in, py_in, i_in;
   logic               last_in;

   always_comb begin
      xs = clamp_coord(req_x_start);
      ys = clamp_coord(req_y_start);
      xe = clamp_coord(req_x_end);
      ye = clamp_coord(req_y_end);
      sx_load  = (xe < xs);
      sy_load  = (ye < ys);
      adx_load = sx_load ? (xs - xe) : (xe - xs);
      ady_load = sy_load ? (ys - ye) : (ye - ys);
      n_load   = (adx_load > ady_load) ? adx_load : ady_load;
   end

   // running remainder of i*|d|/n; at most one carry per step since |d| <= n
   always_comb begin
      rx_sum = {1'b0, rx_ff} + {1'b0, adx_ff};
      ry_sum = {1'b0, ry_ff} + {1'b0, ady_ff};
      cx     = (rx_sum >= {1'b0, n_ff});
      cy     = (ry_sum >= {1'b0, n_ff});
      rx_in  = cx ? COORD_W'(rx_sum - {1'b0, n_ff}) : COORD_W'(rx_sum);
      ry_in  = cy ? COORD_W'(ry_sum - {1'b0, n_ff}) : COORD_W'(ry_sum);
      px_in  = px_ff;
      py_in  = py_ff;
      if (cx) begin
         px_in = sx_ff ? (px_ff - COORD_W'(1)) : (px_ff + COORD_W'(1));
      end
      if (cy) begin
         py_in = sy_ff ? (py_ff - COORD_W'(1)) : (py_ff + COORD_W'(1));
      end
      i_in    = i_ff + COORD_W'(1);
      last_in = (i_in == n_ff);
   end

   // the output register is kept apart from the running point so a new segment
   // can load while the last point of the previous one still waits
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff   <= xs;
         py_ff   <= ys;
         adx_ff  <= adx_load;
         ady_ff  <= ady_load;
         sx_ff   <= sx_load;
         sy_ff   <= sy_load;
         n_ff    <= n_load;
         rx_ff   <= '0;
         ry_ff   <= '0;
         i_ff    <= '0;
      end else if (cmd.step) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pt_x_ff <= px_in;
         pt_y_ff <= py_in;
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         i_ff    <= i_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.step) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign status.n_zero    = (n_ff == '0);
   assign status.step_last = last_in;
   assign status.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid   = valid_ff;
   assign rsp_point_x = pt_x_ff;
   assign rsp_point_y = pt_y_ff;
   assign rsp_last    = last_ff;

endmodule

/* src/dda_line_point_generator_checker.sv */
`include "dda_line_point_generator_defines.svh"

module dda_line_point_generator_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [dda_pkg::COORD_W-1:0] req_x_start,
   input logic [dda_pkg::COORD_W-1:0] req_y_start,
   input logic [dda_pkg::COORD_W-1:0] req_x_end,
   input logic [dda_pkg::COORD_W-1:0] req_y_end,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dda_pkg::COORD_W-1:0] rsp_point_x,
   input logic [dda_pkg::COORD_W-1:0] rsp_point_y,
   input logic                        rsp_last
);

   // a stalled result keeps its payload
   `DDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_last), "stalled result changed")

   // a segment is in progress after each accepted transaction
   `DDA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "input taken while a segment is in progress")

   // a point that is not the last of its segment means the segment is still running
   `DDA_ASSERT_SAME(a_no_accept_mid_segment, clock, reset, rsp_valid && !rsp_last, !req_ready, "input ready before the segment finished")

   // identical endpoints return to idle without emitting
   `DDA_ASSERT_NEXT(a_empty_segment, clock, reset, req_valid && req_ready && req_x_start == req_x_end && req_y_start == req_y_end, ##1 req_ready, "empty segment did not finish at once")

endmodule

bind dda_line_point_generator dda_line_point_generator_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_x_start (req_x_start),
   .req_y_start (req_y_start),
   .req_x_end   (req_x_end),
   .req_y_end   (req_y_end),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y),
   .rsp_last    (rsp_last)
);

/* tb/sv/tb_dda_line_point_generator.sv */
`timescale 1ns / 100ps

module tb_dda_line_point_generator;
   import dda_pkg::*;

   localparam int NUM_RANDOM  = 250;
   localparam int DRAIN_WAIT  = 100;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
   } segment_t;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } point_t;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [COORD_W-1:0] req_x_start;
   logic [COORD_W-1:0] req_y_start;
   logic [COORD_W-1:0] req_x_end;
   logic [COORD_W-1:0] req_y_end;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [COORD_W-1:0] rsp_point_x;
   logic [COORD_W-1:0] rsp_point_y;
   logic               rsp_last;

   segment_t segment_queue[$];
   point_t   expected_points[$];
   int       error_count = 0;
   int       cycle_count = 0;
   int       req_gap     = 0;
   int       rsp_stall   = 0;
   bit       req_burst   = 0;
   bit       rsp_burst   = 0;

   dda_line_point_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_last    (rsp_last)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // points start + i*(end-start)/n for i = 1..n, quotient truncated toward zero
   task automatic plot_segment_points(input segment_t s);
      int     dx;
      int     dy;
      int     n;
      int     px;
      int     py;
      point_t p;
      dx = int'(s.x1) - int'(s.x0);
      dy = int'(s.y1) - int'(s.y0);
      n  = (dx < 0) ? -dx : dx;
      if (((dy < 0) ? -dy : dy) > n) begin
         n = (dy < 0) ? -dy : dy;
      end
      for (int i = 1; i <= n; i++) begin
         px     = int'(s.x0) + (i * dx) / n;
         py     = int'(s.y0) + (i * dy) / n;
         p.x    = px[COORD_W-1:0];
         p.y    = py[COORD_W-1:0];
         p.last = (i == n);
         expected_points.push_back(p);
      end
   endtask

   task automatic add_segment(input int x0, input int y0, input int x1, input int y1);
      segment_t s;
      s.x0 = x0[COORD_W-1:0];
      s.y0 = y0[COORD_W-1:0];
      s.x1 = x1[COORD_W-1:0];
      s.y1 = y1[COORD_W-1:0];
      segment_queue.push_back(s);
   endtask

   function automatic int near_coord(input int c);
      int t;
      t = c + int'($urandom_range(0, 14)) - 7;
      if (t < 0) t = 0;
      if (t > GRID_SIZE - 1) t = GRID_SIZE - 1;
      return t;
   endfunction

   task automatic present_next_segment();
      req_x_start <= segment_queue[0].x0;
      req_y_start <= segment_queue[0].y0;
      req_x_end   <= segment_queue[0].x1;
      req_y_end   <= segment_queue[0].y1;
      req_valid   <= 1'b1;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            plot_segment_points('{req_x_start, req_y_start, req_x_end, req_y_end});
            void'(segment_queue.pop_front());
            req_gap = req_burst ? 0 : $urandom_range(0, 10);
            if (req_gap == 0 && segment_queue.size() != 0) begin
               present_next_segment();
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid && segment_queue.size() != 0) begin
            if (req_gap > 0) begin
               req_gap--;
            end else begin
               present_next_segment();
            end
         end
         if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      end
   end

   // monitor
   always @(posedge clock) begin
      point_t exp_pt;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected point transaction: x %0d, y %0d, last %0d",
                      rsp_point_x, rsp_point_y, rsp_last);
               error_count++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_point_x !== exp_pt.x) begin
                  $error("point_x mismatch: expected %0d, actual %0d", exp_pt.x, rsp_point_x);
                  error_count++;
               end
               if (rsp_point_y !== exp_pt.y) begin
                  $error("point_y mismatch: expected %0d, actual %0d", exp_pt.y, rsp_point_y);
                  error_count++;
               end
               if (rsp_last !== exp_pt.last) begin
                  $error("last mismatch: expected %0d, actual %0d", exp_pt.last, rsp_last);
                  error_count++;
               end
            end
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 10);
            if (rsp_stall != 0) begin
               rsp_ready <= 1'b0;
            end
         end else if (!rsp_ready) begin
            if (rsp_stall > 0) begin
               rsp_stall--;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
         if ($urandom_range(0, 49) == 0) rsp_burst = !rsp_burst;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int kind;
      int x0;
      int y0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_x_start = '0;
      req_y_start = '0;
      req_x_end   = '0;
      req_y_end   = '0;
      rsp_ready   = 1'b0;

      // identical endpoints give no points
      add_segment(0, 0, 0, 0);
      add_segment(63, 63, 63, 63);
      add_segment(21, 42, 21, 42);
      // full span diagonals and axes, both directions
      add_segment(0, 0, 63, 63);
      add_segment(63, 63, 0, 0);
      add_segment(63, 0, 0, 63);
      add_segment(0, 5, 63, 5);
      add_segment(63, 40, 0, 40);
      add_segment(7, 0, 7, 63);
      add_segment(50, 63, 50, 0);
      // steep and shallow slopes, negative quotients truncated toward zero
      add_segment(0, 0, 1, 63);
      add_segment(63, 0, 62, 63);
      add_segment(0, 63, 63, 62);
      add_segment(40, 10, 37, 50);
      add_segment(10, 50, 45, 47);
      add_segment(30, 30, 13, 2);
      // single steps and one reverse diagonal
      add_segment(5, 5, 6, 5);
      add_segment(5, 5, 4, 4);
      add_segment(0, 63, 0, 62);
      add_segment(42, 21, 21, 42);

      for (int k = 0; k < NUM_RANDOM; k++) begin
         kind = $urandom_range(0, 9);
         x0   = $urandom_range(0, 63);
         y0   = $urandom_range(0, 63);
         if (kind == 0) begin
            add_segment(x0, y0, x0, y0);
         end else if (kind < 5) begin
            add_segment(x0, y0, near_coord(x0), near_coord(y0));
         end else begin
            add_segment(x0, y0, $urandom_range(0, 63), $urandom_range(0, 63));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (segment_queue.size() != 0 || req_valid || expected_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
